### rtl/psfl_pkg.sv
// ----------------------------------------------------------------------------
// psfl_pkg
// Shared types and constants of the per-source flood limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psfl_pkg;

  // Table geometry
  localparam int SOURCE_SLOTS = 256;
  localparam int RECS_PER_SRC = 8;
  localparam int SLOT_W       = $clog2(SOURCE_SLOTS);
  localparam int REC_W        = (RECS_PER_SRC > 1) ? $clog2(RECS_PER_SRC) : 1;
  localparam int RADDR_W      = SLOT_W + REC_W;
  localparam int TOTAL_RECS   = SOURCE_SLOTS * (1 << REC_W);

  // Field widths
  localparam int KEY_W  = 48;
  localparam int TIME_W = 32;
  localparam int MS_W   = 18;
  localparam int TOK_W  = 20;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SOURCE_SLOTS - 1);
  localparam logic [REC_W-1:0]  REC_LAST  = REC_W'(RECS_PER_SRC - 1);
  localparam logic signed [21:0] TOKEN_MIN = -22'sd524288;

  // Verdict codes
  localparam logic [1:0] V_ALLOW   = 2'd0;
  localparam logic [1:0] V_DROP    = 2'd1;
  localparam logic [1:0] V_MASSIVE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LAN_MODE  = 3'd0;
  localparam logic [2:0] REG_CAP       = 3'd1;
  localparam logic [2:0] REG_MASSIVE   = 3'd2;
  localparam logic [2:0] REG_AGG_COST  = 3'd3;
  localparam logic [2:0] REG_IDLE_TOUT = 3'd4;

  // Reset values
  localparam logic [MS_W-1:0]   CAP_RST     = 18'd60000;
  localparam logic [MS_W-1:0]   MASSIVE_RST = 18'd180000;
  localparam logic [MS_W-1:0]   AGG_RST     = 18'd500;
  localparam logic [TIME_W-1:0] TOUT_RST    = 32'd720000;

  typedef struct packed {
    logic              lan_mode;
    logic [MS_W-1:0]   cap;
    logic [MS_W-1:0]   massive;
    logic [MS_W-1:0]   agg_cost;
    logic [TIME_W-1:0] idle_tout;
  } cfg_t;

  // Classified item handed from front to engine
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [31:0]       ip;
    logic [15:0]       port;
    logic [7:0]        opc;
    logic [MS_W-1:0]   cost;
    logic              scoped;
    logic              lan_skip;
    logic              tracked;
  } job_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       ban;
    logic       full;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SW_RD, ST_SW_CK, ST_SR_RD, ST_SR_CK, ST_SRC_WR, ST_RR_RD,
    ST_RR_CK, ST_MASK_WR, ST_REFILL, ST_UPDATE, ST_NEXT, ST_DONE
  } eng_state_e;

endpackage

`default_nettype wire

### rtl/psfl_front.sv
// ----------------------------------------------------------------------------
// psfl_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psfl_front import psfl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              lan_mode_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  input  wire logic [31:0]       source_ip_i,
  input  wire logic [15:0]       source_port_i,
  input  wire logic [7:0]        opcode_i,
  input  wire logic [MS_W-1:0]   cost_ms_i,
  input  wire logic              endpoint_scoped_i,
  input  wire logic              lan_source_i,
  output logic                   job_valid_o,
  output job_t                   job_o,
  input  wire logic              job_pop_i
);

  job_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  job_t       job_in;

  // Classify the item
  always_comb begin
    job_in.now      = now_ms_i;
    job_in.ip       = source_ip_i;
    job_in.port     = source_port_i;
    job_in.opc      = opcode_i;
    job_in.cost     = cost_ms_i;
    job_in.scoped   = endpoint_scoped_i;
    job_in.lan_skip = lan_mode_i & lan_source_i;
    job_in.tracked  = (cost_ms_i != '0);
  end

  assign full_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = buf_q[rd_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = job_pop_i & job_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/psfl_engine.sv
// ----------------------------------------------------------------------------
// psfl_engine
// Sweeps idle sources, looks up source slots and opcode records, and
// charges token buckets, one item at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psfl_engine import psfl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  output logic      res_push_o,
  output result_t   res_o,
  input  wire logic res_full_i
);

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [TIME_W-1:0]       seen;
    logic [RECS_PER_SRC-1:0] mask;
  } src_row_t;

  typedef struct packed {
    logic [7:0]        opc;
    logic [TOK_W-1:0]  tok;
    logic [TIME_W-1:0] latest;
  } rec_row_t;

  // Memories
  src_row_t src_mem [SOURCE_SLOTS];
  rec_row_t rec_mem [TOTAL_RECS];
  src_row_t src_rd_q, src_wdata;
  rec_row_t rec_rd_q, rec_wdata;
  logic [SLOT_W-1:0]  src_raddr, src_waddr;
  logic [RADDR_W-1:0] rec_raddr, rec_waddr;
  logic src_we, rec_we;

  eng_state_e state_q, state_d;
  job_t       job_q;
  logic [SOURCE_SLOTS-1:0] valid_q;
  logic [SLOT_W-1:0] idx_q, slot_q, free_slot_q;
  logic              free_found_q;
  logic [REC_W-1:0]  ridx_q, rec_q, free_rec_q;
  logic              free_rec_found_q;
  logic [RECS_PER_SRC-1:0] mask_q;
  logic              ph_q, full_q, ban_q;
  logic [1:0]        chg_q, verdict_q;
  logic signed [20:0] tok_q;
  logic [TIME_W-1:0] last_sweep_q;

  // Parameters of the current charge
  logic [KEY_W-1:0] cur_key;
  logic [MS_W-1:0]  cur_cost;
  logic             allow_ban, expire_ep;
  assign cur_key   = (job_q.scoped && ph_q) ? {job_q.ip, job_q.port} : {job_q.ip, 16'h0};
  assign cur_cost  = (job_q.scoped && !ph_q) ? cfg_i.agg_cost : job_q.cost;
  assign allow_ban = ~job_q.scoped;
  assign expire_ep = job_q.scoped & ph_q;

  // Scan decisions
  logic sweep_due, sw_expire, src_hit, src_free_here, src_any_free;
  logic rec_hit, rec_free_here, rec_any_free;
  logic [SLOT_W-1:0] alloc_slot;
  logic [REC_W-1:0]  alloc_rec;
  assign sweep_due     = (job_i.now - last_sweep_q) >= cfg_i.idle_tout;
  assign sw_expire     = valid_q[idx_q] && ((job_q.now - src_rd_q.seen) >= cfg_i.idle_tout);
  assign src_hit       = valid_q[idx_q] && (src_rd_q.key == cur_key);
  assign src_free_here = ~valid_q[idx_q] & ~free_found_q;
  assign src_any_free  = free_found_q | ~valid_q[idx_q];
  assign alloc_slot    = free_found_q ? free_slot_q : idx_q;
  assign rec_hit       = mask_q[ridx_q] && (rec_rd_q.opc == job_q.opc);
  assign rec_free_here = ~mask_q[ridx_q] & ~free_rec_found_q;
  assign rec_any_free  = free_rec_found_q | ~mask_q[ridx_q];
  assign alloc_rec     = free_rec_found_q ? free_rec_q : ridx_q;

  // Bucket arithmetic
  logic [TIME_W-1:0]  elapsed;
  logic signed [20:0] refill_sum, cap_s, refill;
  logic signed [21:0] t_raw, t_sat, neg_lim;
  logic [TOK_W-1:0]   new_tok;
  logic [1:0]         upd_verdict;
  assign elapsed    = job_q.now - rec_rd_q.latest;
  assign cap_s      = $signed({3'b000, cfg_i.cap});
  assign refill_sum = $signed({rec_rd_q.tok[TOK_W-1], rec_rd_q.tok})
                    + $signed({3'b000, elapsed[MS_W-1:0]});
  assign refill     = (elapsed >= {14'h0, cfg_i.cap}) ? cap_s :
                      ((refill_sum > cap_s) ? cap_s : refill_sum);
  assign t_raw      = $signed({tok_q[20], tok_q}) - $signed({4'h0, cur_cost});
  assign t_sat      = (t_raw < TOKEN_MIN) ? TOKEN_MIN : t_raw;
  assign neg_lim    = 22'sd0 - $signed({4'h0, cfg_i.massive});
  assign new_tok    = {2'b00, cfg_i.cap} - {2'b00, cur_cost};

  always_comb begin
    if (job_q.lan_skip || t_sat >= 22'sd0) begin
      upd_verdict = V_ALLOW;
    end else if (t_sat < neg_lim && (allow_ban || expire_ep)) begin
      upd_verdict = V_MASSIVE;
    end else begin
      upd_verdict = V_DROP;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          if (!job_i.tracked)  state_d = ST_DONE;
          else if (sweep_due)  state_d = ST_SW_RD;
          else                 state_d = ST_SR_RD;
        end
      end
      ST_SW_RD:   state_d = ST_SW_CK;
      ST_SW_CK:   state_d = (idx_q == SLOT_LAST) ? ST_SR_RD : ST_SW_RD;
      ST_SR_RD:   state_d = ST_SR_CK;
      ST_SR_CK: begin
        if (src_hit) state_d = ST_SRC_WR;
        else if (idx_q == SLOT_LAST) state_d = src_any_free ? ST_SRC_WR : ST_NEXT;
        else state_d = ST_SR_RD;
      end
      ST_SRC_WR:  state_d = ST_RR_RD;
      ST_RR_RD:   state_d = ST_RR_CK;
      ST_RR_CK: begin
        if (rec_hit) state_d = ST_REFILL;
        else if (ridx_q == REC_LAST) state_d = rec_any_free ? ST_MASK_WR : ST_NEXT;
        else state_d = ST_RR_RD;
      end
      ST_MASK_WR: state_d = ST_NEXT;
      ST_REFILL:  state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_NEXT;
      ST_NEXT: begin
        if (job_q.scoped && !ph_q && chg_q == V_ALLOW) state_d = ST_SR_RD;
        else state_d = ST_DONE;
      end
      ST_DONE:    state_d = res_full_i ? ST_DONE : ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory control
  always_comb begin
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    src_we     = 1'b0;
    rec_we     = 1'b0;
    src_raddr  = idx_q;
    src_waddr  = slot_q;
    src_wdata  = '{key: cur_key, seen: job_q.now, mask: mask_q};
    rec_raddr  = {slot_q, ridx_q};
    rec_waddr  = {slot_q, rec_q};
    rec_wdata  = '{opc: job_q.opc, tok: t_sat[TOK_W-1:0], latest: job_q.now};
    case (state_q)
      ST_IDLE:    job_pop_o = job_valid_i;
      ST_SRC_WR:  src_we = 1'b1;
      ST_MASK_WR: src_we = 1'b1;
      ST_RR_CK: begin
        if (!rec_hit && ridx_q == REC_LAST && rec_any_free) begin
          rec_we    = 1'b1;
          rec_waddr = {slot_q, alloc_rec};
          rec_wdata = '{opc: job_q.opc, tok: new_tok, latest: job_q.now};
        end
      end
      ST_UPDATE:  rec_we = 1'b1;
      ST_DONE:    res_push_o = ~res_full_i;
      default:    ;
    endcase
  end

  assign res_o = '{verdict: verdict_q, ban: ban_q, full: full_q};

  // Memory arrays
  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_rd_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    rec_rd_q <= rec_mem[rec_raddr];
  end

  // Item payload and bucket working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == ST_REFILL) tok_q <= refill;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      valid_q          <= '0;
      last_sweep_q     <= '0;
      idx_q            <= '0;
      slot_q           <= '0;
      free_slot_q      <= '0;
      free_found_q     <= 1'b0;
      ridx_q           <= '0;
      rec_q            <= '0;
      free_rec_q       <= '0;
      free_rec_found_q <= 1'b0;
      mask_q           <= '0;
      ph_q             <= 1'b0;
      full_q           <= 1'b0;
      ban_q            <= 1'b0;
      chg_q            <= V_ALLOW;
      verdict_q        <= V_ALLOW;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          idx_q        <= '0;
          free_found_q <= 1'b0;
          ph_q         <= 1'b0;
          full_q       <= 1'b0;
          ban_q        <= 1'b0;
          verdict_q    <= V_ALLOW;
          if (job_valid_i && job_i.tracked && sweep_due) last_sweep_q <= job_i.now;
        end
        ST_SW_CK: begin
          if (sw_expire) valid_q[idx_q] <= 1'b0;
          idx_q <= idx_q + 1'b1;
        end
        ST_SR_CK: begin
          idx_q <= idx_q + 1'b1;
          if (src_free_here) begin
            free_found_q <= 1'b1;
            free_slot_q  <= idx_q;
          end
          if (src_hit) begin
            slot_q <= idx_q;
            mask_q <= src_rd_q.mask;
          end else if (idx_q == SLOT_LAST) begin
            if (src_any_free) begin
              slot_q              <= alloc_slot;
              mask_q              <= '0;
              valid_q[alloc_slot] <= 1'b1;
            end else begin
              full_q <= 1'b1;
              chg_q  <= V_ALLOW;
            end
          end
        end
        ST_SRC_WR: begin
          ridx_q           <= '0;
          free_rec_found_q <= 1'b0;
        end
        ST_RR_CK: begin
          ridx_q <= ridx_q + 1'b1;
          if (rec_free_here) begin
            free_rec_found_q <= 1'b1;
            free_rec_q       <= ridx_q;
          end
          if (rec_hit) begin
            rec_q <= ridx_q;
          end else if (ridx_q == REC_LAST) begin
            chg_q <= V_ALLOW;
            if (rec_any_free) mask_q[alloc_rec] <= 1'b1;
            else full_q <= 1'b1;
          end
        end
        ST_UPDATE: begin
          chg_q <= upd_verdict;
          if (upd_verdict == V_MASSIVE && allow_ban) ban_q <= 1'b1;
        end
        ST_NEXT: begin
          if (job_q.scoped && !ph_q) begin
            if (chg_q == V_ALLOW) begin
              ph_q         <= 1'b1;
              idx_q        <= '0;
              free_found_q <= 1'b0;
            end else begin
              verdict_q <= V_DROP;
            end
          end else begin
            verdict_q <= chg_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_push_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> state_q == ST_DONE) else $error("result pushed outside done");
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.verdict == V_ALLOW || res_o.verdict == V_DROP ||
                    res_o.verdict == V_MASSIVE)) else $error("bad verdict code");
  a_ban_massive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.ban) |-> res_o.verdict == V_MASSIVE)
    else $error("ban without massive flood");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> state_q != ST_IDLE) else $error("item popped but engine idle");

endmodule

`default_nettype wire

### rtl/per_source_flood_limiter_core.sv
// ----------------------------------------------------------------------------
// per_source_flood_limiter_core
// Token-bucket flood limiter per source and opcode, with APB configuration.
// ----------------------------------------------------------------------------
// Items are processed one at a time by a sequential engine that scans the
// source table one slot at a time (memory read, then compare) and the
// source's opcode records the same way. A bucket charge does a full source
// scan (it ends early on a hit), writes the source row, scans the records,
// then refills, updates and finishes. Endpoint-scoped items charge the
// address bucket and, only if that allows, an address-and-port bucket. An
// idle sweep over all 256 source slots comes first when due, and every item
// also passes through the idle and result states. Untracked items (cost 0)
// go from idle straight to the result state. A two-entry queue at the input
// and one at the output let both sides stall independently.
`timescale 1ns / 1ps
`default_nettype none

module per_source_flood_limiter_core import psfl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Item input
  input  wire logic              push,
  output logic                   full,
  input  wire logic [TIME_W-1:0] now_ms_i,
  input  wire logic [31:0]       source_ip_i,
  input  wire logic [15:0]       source_port_i,
  input  wire logic [7:0]        opcode_i,
  input  wire logic [MS_W-1:0]   cost_ms_i,
  input  wire logic              endpoint_scoped_i,
  input  wire logic              lan_source_i,
  // Result output
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             verdict_o,
  output logic                   ban_request_o,
  output logic                   table_full_o,
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t    cfg_q;
  logic    cfg_we;
  logic    job_valid, job_pop, res_push;
  job_t    job;
  result_t res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lan_mode  <= 1'b0;
      cfg_q.cap       <= CAP_RST;
      cfg_q.massive   <= MASSIVE_RST;
      cfg_q.agg_cost  <= AGG_RST;
      cfg_q.idle_tout <= TOUT_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_LAN_MODE:  cfg_q.lan_mode  <= pwdata[0];
        REG_CAP:       cfg_q.cap       <= pwdata[MS_W-1:0];
        REG_MASSIVE:   cfg_q.massive   <= pwdata[MS_W-1:0];
        REG_AGG_COST:  cfg_q.agg_cost  <= pwdata[MS_W-1:0];
        REG_IDLE_TOUT: cfg_q.idle_tout <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LAN_MODE:  prdata = {31'h0, cfg_q.lan_mode};
      REG_CAP:       prdata = {14'h0, cfg_q.cap};
      REG_MASSIVE:   prdata = {14'h0, cfg_q.massive};
      REG_AGG_COST:  prdata = {14'h0, cfg_q.agg_cost};
      REG_IDLE_TOUT: prdata = cfg_q.idle_tout;
      default:       prdata = '0;
    endcase
  end

  psfl_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .lan_mode_i        (cfg_q.lan_mode),
    .now_ms_i          (now_ms_i),
    .source_ip_i       (source_ip_i),
    .source_port_i     (source_port_i),
    .opcode_i          (opcode_i),
    .cost_ms_i         (cost_ms_i),
    .endpoint_scoped_i (endpoint_scoped_i),
    .lan_source_i      (lan_source_i),
    .job_valid_o       (job_valid),
    .job_o             (job),
    .job_pop_i         (job_pop)
  );

  // Result queue
  result_t    rq_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_full, rq_pop;

  assign rq_full = (rq_cnt_q == 2'd2);
  assign empty   = (rq_cnt_q == 2'd0);
  assign rq_pop  = pop & ~empty;

  psfl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (rq_full)
  );

  always_ff @(posedge clk_i) begin
    if (res_push) rq_q[rq_wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (res_push) rq_wr_q <= ~rq_wr_q;
      if (rq_pop)   rq_rd_q <= ~rq_rd_q;
      rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(rq_pop);
    end
  end

  assign verdict_o     = rq_q[rq_rd_q].verdict;
  assign ban_request_o = rq_q[rq_rd_q].ban;
  assign table_full_o  = rq_q[rq_rd_q].full;

endmodule

`default_nettype wire

### test/per_source_flood_limiter_core_checker.sv
// ----------------------------------------------------------------------------
// per_source_flood_limiter_core_checker
// Watches the item, result and APB channels of the flood limiter, keeps its
// own token-bucket tables, predicts each verdict and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_source_flood_limiter_core_checker import psfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [31:0]       source_ip_i,
  input  logic [15:0]       source_port_i,
  input  logic [7:0]        opcode_i,
  input  logic [MS_W-1:0]   cost_ms_i,
  input  logic              endpoint_scoped_i,
  input  logic              lan_source_i,
  input  logic              empty,
  input  logic              pop,
  input  logic [1:0]        verdict_o,
  input  logic              ban_request_o,
  input  logic              table_full_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatch_cnt_o,
  output int                verdicts_owed_o
);

  localparam int NSRC = SOURCE_SLOTS;
  localparam int NREC = RECS_PER_SRC;

  // Mirrored configuration
  cfg_t shadow_cfg;

  // Mirrored tables
  logic [KEY_W-1:0]  src_key    [NSRC];
  logic [TIME_W-1:0] src_seen   [NSRC];
  bit                src_live   [NSRC];
  logic [7:0]        bkt_opc    [NSRC*NREC];
  longint            bkt_tokens [NSRC*NREC];
  logic [TIME_W-1:0] bkt_latest [NSRC*NREC];
  bit                bkt_live   [NSRC*NREC];
  logic [TIME_W-1:0] sweep_stamp;

  bit      pred_ban, pred_full;
  result_t owed_verdicts[$];
  int      mismatches;

  assign mismatch_cnt_o  = mismatches;
  assign verdicts_owed_o = owed_verdicts.size();

  // Drop every source that has been idle too long
  function automatic void sweep_idle(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    sweep_stamp = now;
    for (int s = 0; s < NSRC; s++) begin
      age = now - src_seen[s];
      if (src_live[s] && age >= shadow_cfg.idle_tout) begin
        src_live[s] = 0;
        for (int r = 0; r < NREC; r++) bkt_live[s*NREC+r] = 0;
      end
    end
  endfunction

  // Charge one bucket, returns the verdict of that charge
  function automatic logic [1:0] charge_bucket(logic [KEY_W-1:0] key,
      logic [TIME_W-1:0] now, logic [7:0] opc, logic [MS_W-1:0] cost,
      bit may_ban, bit ep_scoped, bit lan_skip);
    int slot, free_slot, rec, free_rec;
    logic [TIME_W-1:0] elapsed;
    longint t;
    slot = -1; free_slot = -1; rec = -1; free_rec = -1;
    for (int s = 0; s < NSRC; s++) begin
      if (src_live[s]) begin
        if (src_key[s] == key) begin
          slot = s;
          break;
        end
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        pred_full = 1;
        return V_ALLOW;
      end
      slot = free_slot;
      src_live[slot] = 1;
      src_key[slot] = key;
      for (int r = 0; r < NREC; r++) bkt_live[slot*NREC+r] = 0;
    end
    src_seen[slot] = now;
    for (int r = slot*NREC; r < (slot+1)*NREC; r++) begin
      if (bkt_live[r]) begin
        if (bkt_opc[r] == opc) begin
          rec = r;
          break;
        end
      end else if (free_rec < 0) begin
        free_rec = r;
      end
    end
    if (rec < 0) begin
      if (free_rec < 0) begin
        pred_full = 1;
        return V_ALLOW;
      end
      bkt_live[free_rec] = 1;
      bkt_opc[free_rec] = opc;
      bkt_tokens[free_rec] = longint'(shadow_cfg.cap) - longint'(cost);
      bkt_latest[free_rec] = now;
      return V_ALLOW;
    end
    // refill by elapsed time, capped, then charge with saturation
    elapsed = now - bkt_latest[rec];
    if (elapsed >= shadow_cfg.cap) begin
      t = longint'(shadow_cfg.cap);
    end else begin
      t = bkt_tokens[rec] + longint'(elapsed);
      if (t > longint'(shadow_cfg.cap)) t = longint'(shadow_cfg.cap);
    end
    t -= longint'(cost);
    if (t < -524288) t = -524288;
    bkt_tokens[rec] = t;
    bkt_latest[rec] = now;
    if (lan_skip) return V_ALLOW;
    if (t < 0) begin
      if (t < -longint'(shadow_cfg.massive)) begin
        if (may_ban) begin
          pred_ban = 1;
          return V_MASSIVE;
        end
        return ep_scoped ? V_MASSIVE : V_DROP;
      end
      return V_DROP;
    end
    return V_ALLOW;
  endfunction

  function automatic result_t judge_item();
    result_t res;
    logic [KEY_W-1:0] ip_key;
    bit lan_skip;
    logic [1:0] v;
    pred_ban = 0;
    pred_full = 0;
    v = V_ALLOW;
    ip_key = {source_ip_i, 16'h0};
    lan_skip = shadow_cfg.lan_mode && lan_source_i;
    if (cost_ms_i != 0) begin
      if (TIME_W'(now_ms_i - sweep_stamp) >= shadow_cfg.idle_tout) sweep_idle(now_ms_i);
      if (endpoint_scoped_i) begin
        if (charge_bucket(ip_key, now_ms_i, opcode_i, shadow_cfg.agg_cost, 0, 0,
                          lan_skip) != V_ALLOW)
          v = V_DROP;
        else
          v = charge_bucket(ip_key | KEY_W'(source_port_i), now_ms_i, opcode_i,
                            cost_ms_i, 0, 1, lan_skip);
      end else begin
        v = charge_bucket(ip_key, now_ms_i, opcode_i, cost_ms_i, 1, 0, lan_skip);
      end
    end
    res.verdict = v;
    res.ban = pred_ban;
    res.full = pred_full;
    return res;
  endfunction

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      shadow_cfg.lan_mode  = 0;
      shadow_cfg.cap       = CAP_RST;
      shadow_cfg.massive   = MASSIVE_RST;
      shadow_cfg.agg_cost  = AGG_RST;
      shadow_cfg.idle_tout = TOUT_RST;
      for (int s = 0; s < NSRC; s++) src_live[s] = 0;
      for (int r = 0; r < NSRC*NREC; r++) bkt_live[r] = 0;
      sweep_stamp = 0;
      owed_verdicts.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LAN_MODE:  shadow_cfg.lan_mode  = pwdata[0];
          REG_CAP:       shadow_cfg.cap       = pwdata[MS_W-1:0];
          REG_MASSIVE:   shadow_cfg.massive   = pwdata[MS_W-1:0];
          REG_AGG_COST:  shadow_cfg.agg_cost  = pwdata[MS_W-1:0];
          REG_IDLE_TOUT: shadow_cfg.idle_tout = pwdata;
          default: ;
        endcase
      end
      if (push && !full) owed_verdicts.push_back(judge_item());
      if (pop && !empty) begin
        if (owed_verdicts.size() == 0) begin
          $display("%0t: unexpected item verdict=%0d ban=%0d full=%0d", $time,
                   verdict_o, ban_request_o, table_full_o);
          mismatches++;
        end else begin
          want = owed_verdicts.pop_front();
          if (verdict_o !== want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, verdict_o);
            mismatches++;
          end
          if (ban_request_o !== want.ban) begin
            $display("%0t: ban_request expected %0d actual %0d", $time, want.ban,
                     ban_request_o);
            mismatches++;
          end
          if (table_full_o !== want.full) begin
            $display("%0t: table_full expected %0d actual %0d", $time, want.full,
                     table_full_o);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

### test/per_source_flood_limiter_core_test.sv
// ----------------------------------------------------------------------------
// per_source_flood_limiter_core_test
// Drives packets and register writes into the flood limiter under random
// stalls on both sides; the checker beside the block judges every verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_source_flood_limiter_core_test;
  import psfl_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic push = 0;
  logic [TIME_W-1:0] now_ms_i = 0;
  logic [31:0] source_ip_i = 0;
  logic [15:0] source_port_i = 0;
  logic [7:0] opcode_i = 0;
  logic [MS_W-1:0] cost_ms_i = 0;
  logic endpoint_scoped_i = 0, lan_source_i = 0;
  logic pop = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire full, empty, ban_request_o, table_full_o, pready;
  wire [1:0] verdict_o;
  wire [31:0] prdata;
  int mismatch_cnt, verdicts_owed;

  logic [TIME_W-1:0] clock_ms;
  logic [31:0] ip_pool[8];
  logic [15:0] port_pool[4];
  int packets_sent;

  per_source_flood_limiter_core DUT (.*);

  per_source_flood_limiter_core_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .now_ms_i, .source_ip_i, .source_port_i,
    .opcode_i, .cost_ms_i, .endpoint_scoped_i, .lan_source_i, .empty, .pop,
    .verdict_o, .ban_request_o, .table_full_o, .psel, .penable, .pwrite,
    .paddr, .pwdata, .pready, .mismatch_cnt_o(mismatch_cnt),
    .verdicts_owed_o(verdicts_owed));

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #250ms;
    $display("Mismatches found");
    $finish;
  end

  // Result side: pop in runs with random stalls
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 40);
      pop <= 1;
      repeat (n) @(posedge clk_i);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(0, 4);
      if (n > 0) begin
        pop <= 0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_limits(logic lan, logic [MS_W-1:0] cap, logic [MS_W-1:0] massive,
                            logic [MS_W-1:0] agg, logic [31:0] tout);
    apb_write(REG_LAN_MODE, {31'b0, lan});
    apb_write(REG_CAP, {14'b0, cap});
    apb_write(REG_MASSIVE, {14'b0, massive});
    apb_write(REG_AGG_COST, {14'b0, agg});
    apb_write(REG_IDLE_TOUT, tout);
  endtask

  // Let every owed verdict come back, then some settle time
  task automatic drain();
    push <= 0;
    @(posedge clk_i);
    while (verdicts_owed != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic send_packet(logic [31:0] now, logic [31:0] ip, logic [15:0] port,
                             logic [7:0] opc, logic [MS_W-1:0] cost, logic ep,
                             logic lan);
    int gap;
    now_ms_i <= now; source_ip_i <= ip; source_port_i <= port; opcode_i <= opc;
    cost_ms_i <= cost; endpoint_scoped_i <= ep; lan_source_i <= lan;
    push <= 1;
    do @(posedge clk_i); while (full);
    packets_sent++;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 2000)
        : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 5));
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random traffic over a small pool of sources so buckets get hammered
  task automatic random_traffic(int n, int step_max);
    logic [MS_W-1:0] cost;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) clock_ms += $urandom;
      else clock_ms += $urandom_range(0, step_max);
      sel = $urandom_range(0, 9);
      cost = (sel == 0) ? 18'd0 : (sel == 1) ? 18'($urandom_range(0, 262143))
           : (sel == 2) ? 18'h3FFFF : 18'($urandom_range(1, 3000));
      send_packet(clock_ms, ip_pool[$urandom_range(0, 7)],
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)],
                  ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10)),
                  cost, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    clock_ms = 0;
    packets_sent = 0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;
    port_pool[0] = 16'h0; port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'($urandom); port_pool[3] = 16'($urandom);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: untracked, new bucket, repeat charges, floods, scoped, port zero
    send_packet(0, ip_pool[2], 16'h1234, 8'd5, 0, 0, 0);
    send_packet(10, ip_pool[2], 16'h1234, 8'd5, 18'h3FFFF, 0, 0);
    send_packet(20, ip_pool[2], 16'h1234, 8'd5, 18'h3FFFF, 0, 0);
    send_packet(30, ip_pool[2], 16'h1234, 8'd5, 18'h3FFFF, 0, 0);
    send_packet(40, ip_pool[2], 16'h1234, 8'd5, 18'h3FFFF, 0, 0);
    send_packet(50, ip_pool[3], 16'hFFFF, 8'hFF, 18'd100000, 1, 0);
    send_packet(60, ip_pool[3], 16'hFFFF, 8'hFF, 18'h3FFFF, 1, 0);
    send_packet(70, ip_pool[3], 16'hFFFF, 8'hFF, 18'h3FFFF, 1, 0);
    send_packet(80, ip_pool[3], 16'h0, 8'h0, 18'd70000, 1, 0);
    send_packet(90, ip_pool[3], 16'h0, 8'h0, 18'd70000, 1, 1);
    send_packet(100000, ip_pool[2], 16'h1234, 8'd5, 18'd1, 0, 0);
    for (int k = 0; k < 10; k++)
      send_packet(100100 + k, ip_pool[4], 16'h77, 8'(k), 18'd10, 0, 0);
    send_packet(32'hFFFF_FFF0, ip_pool[2], 16'h0, 8'd5, 18'd1, 0, 0);
    send_packet(32'h0000_0010, ip_pool[1], 16'h0, 8'd5, 18'd1, 0, 1);
    drain();

    // Extremes low, LAN bypass on, sweep whenever the clock moves on
    set_limits(1, 18'd1, 18'd1, 18'd1, 32'd1);
    clock_ms = 32'hFFFF_0000;
    random_traffic(300, 3);
    drain();

    // Extremes high; fill the source table with distinct sources
    set_limits(0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 280; k++)
      send_packet(clock_ms + k, $urandom, 16'($urandom), 8'($urandom),
                  18'($urandom_range(1, 262143)), $urandom_range(0, 5) == 0, 0);
    drain();

    // Default-ish limits, fresh sweep state reached by a long step
    set_limits(0, 18'd60000, 18'd180000, 18'd500, 32'd720000);
    clock_ms += 32'h8000_0000;
    random_traffic(350, 2000);
    drain();

    set_limits(1, 18'd2000, 18'd5000, 18'd300, 32'd20000);
    random_traffic(350, 500);
    drain();

    set_limits(0, 18'($urandom_range(1, 262143)), 18'($urandom_range(1, 262143)),
               18'($urandom_range(1, 262143)), $urandom_range(1, 200000));
    random_traffic(300, 5000);
    drain();

    set_limits(0, 18'd500, 18'd1000, 18'd100, 32'd3000);
    random_traffic(250, 100);
    drain();

    $display("Sent %0d packets across seven register settings, table fill and sweeps,",
             packets_sent);
    $display("with random stalls on input and output.");
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
